@@ design/mset_pkg.sv @@
// package for the multi-slot event timer table: constants, codes and shared types
`default_nettype none
package mset_pkg;

   localparam int SLOTS_DEF = 8;
   localparam int TICK_MS   = 10;
   localparam int MIN_TICKS = 2;
   localparam int REM_W     = 29;
   localparam int SHORT_W   = 33;
   // ceil(2^35 / 10): floor(x * RECIP_10 / 2^35) == x / 10 for every 32-bit x
   localparam logic [31:0] RECIP_10 = 32'hCCCC_CCCD;
   localparam int RECIP_SHIFT = 35;

   typedef enum logic [1:0] {
      ACT_REQUEST = 2'd0,
      ACT_CANCEL  = 2'd1,
      ACT_TICK    = 2'd2,
      ACT_BAD     = 2'd3
   } action_type;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_EXEC   = 7'b0000010,
      ST_MATCH  = 7'b0000100,
      ST_MEND   = 7'b0001000,
      ST_MIN    = 7'b0010000,
      ST_EMIT   = 7'b0100000,
      ST_FINISH = 7'b1000000
   } state_type;

   typedef struct packed {
      logic accept;
      logic exec;
      logic match_step;
      logic match_end;
      logic min_step;
      logic emit_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic is_cancel;
      logic is_tick;
      logic none_fired;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

@@ design/mset_ctrl.sv @@
// controller state machine for the timer table: sequences execute, sweeps and result output
`default_nettype none
module mset_ctrl #(
   parameter int SLOTS = mset_pkg::SLOTS_DEF,
   parameter int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire mset_pkg::status_type sts,
   output mset_pkg::cmd_type         cmd,
   output logic [IW-1:0]             idx
);

   mset_pkg::state_type state_ff, state_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic idx_last;

   assign idx_last  = (idx_ff == IW'(SLOTS - 1));
   assign idx       = idx_ff;
   assign req_ready = (state_ff == mset_pkg::ST_IDLE) && !reset;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      cmd      = '0;
      unique case (state_ff)
         mset_pkg::ST_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.accept = 1'b1;
               state_in   = mset_pkg::ST_EXEC;
            end
         end
         mset_pkg::ST_EXEC: begin
            cmd.exec = 1'b1;
            idx_in   = '0;
            state_in = sts.is_cancel ? mset_pkg::ST_MATCH : mset_pkg::ST_MIN;
         end
         mset_pkg::ST_MATCH: begin
            cmd.match_step = 1'b1;
            if (idx_last) begin
               idx_in   = '0;
               state_in = mset_pkg::ST_MEND;
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end
         mset_pkg::ST_MEND: begin
            cmd.match_end = 1'b1;
            state_in      = mset_pkg::ST_MIN;
         end
         mset_pkg::ST_MIN: begin
            cmd.min_step = 1'b1;
            if (idx_last) begin
               idx_in   = '0;
               state_in = (sts.is_tick && !sts.none_fired) ? mset_pkg::ST_EMIT
                                                            : mset_pkg::ST_FINISH;
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end
         mset_pkg::ST_EMIT: begin
            // idx walks the ages, newest first
            if (sts.out_free) begin
               cmd.emit_step = 1'b1;
               if (idx_last) begin
                  state_in = mset_pkg::ST_FINISH;
               end else begin
                  idx_in = idx_ff + IW'(1);
               end
            end
         end
         mset_pkg::ST_FINISH: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = mset_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mset_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mset_pkg::ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule
`default_nettype wire

@@ design/mset_dp.sv @@
// datapath of the timer table: slot storage, per-slot update, sweeps and output register
`default_nettype none
module mset_dp #(
   parameter int SLOTS = mset_pkg::SLOTS_DEF,
   parameter int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire mset_pkg::cmd_type             cmd,
   input  wire logic [IW-1:0]                 idx,
   output mset_pkg::status_type               sts,
   input  wire logic [1:0]                    req_action,
   input  wire logic [7:0]                    req_message_id,
   input  wire logic [7:0]                    req_event_kind,
   input  wire logic signed [7:0]             req_receiver_id,
   input  wire logic [31:0]                   req_delay_ms,
   input  wire logic [7:0]                    req_tick_count,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_status,
   output logic                               rsp_event_valid,
   output logic signed [7:0]                  rsp_fired_receiver,
   output logic [7:0]                         rsp_fired_kind,
   output logic [7:0]                         rsp_fired_message,
   output logic                               rsp_last,
   output logic [mset_pkg::SHORT_W-1:0]       rsp_shortest_ms,
   output logic [31:0]                        rsp_runtime_ticks
);

   localparam int RW = mset_pkg::REM_W;
   localparam int SW = mset_pkg::SHORT_W;
   localparam int NW = $clog2(SLOTS + 1);

   // captured request
   logic [1:0]        act_ff;
   logic [7:0]        msg_ff, kind_ff, tick_ff;
   logic signed [7:0] rcv_ff;
   logic [31:0]       delay_ff;

   // slot table
   logic [SLOTS-1:0]  active_ff, fired_ff;
   logic [RW-1:0]     rem_ff  [SLOTS];
   logic signed [7:0] srcv_ff [SLOTS];
   logic [7:0]        smsg_ff [SLOTS];
   logic [7:0]        skind_ff[SLOTS];
   logic [IW-1:0]     age_ff  [SLOTS];
   logic [IW-1:0]     dec_ff  [SLOTS];
   logic [31:0]       runtime_ff;

   // sweep results
   logic [RW-1:0]     best_ff;
   logic              found_ff, err_ff;
   logic [IW-1:0]     bage_ff, bslot_ff;
   logic [NW-1:0]     nf_ff, ecnt_ff;

   // output register
   logic              rsp_valid_ff, status_ff, event_ff, last_ff;
   logic signed [7:0] orcv_ff;
   logic [7:0]        okind_ff, omsg_ff;
   logic [SW-1:0]     short_ff;
   logic [31:0]       oruntime_ff;

   logic              out_free;
   logic              free_found;
   logic [IW-1:0]     free_idx;
   logic [63:0]       prod;
   logic [RW-1:0]     quot, new_rem;
   logic              hit;
   logic signed [7:0] hit_rcv;
   logic [7:0]        hit_kind, hit_msg;
   logic [SW-1:0]     best_wide, shortest;

   assign out_free = !rsp_valid_ff || rsp_ready;

   assign sts.is_cancel  = (act_ff == mset_pkg::ACT_CANCEL);
   assign sts.is_tick    = (act_ff == mset_pkg::ACT_TICK);
   assign sts.none_fired = ~|fired_ff;
   assign sts.out_free   = out_free;

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!active_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IW'(i);
         end
      end
   end

   // delay / 10 by reciprocal multiply
   assign prod    = {32'b0, delay_ff} * {32'b0, mset_pkg::RECIP_10};
   assign quot    = prod[mset_pkg::RECIP_SHIFT +: RW];
   assign new_rem = (delay_ff > 32'(mset_pkg::MIN_TICKS * mset_pkg::TICK_MS))
                    ? quot + RW'(1) : RW'(mset_pkg::MIN_TICKS);

   // fired entry with the age under the walk
   always_comb begin
      hit      = 1'b0;
      hit_rcv  = '0;
      hit_kind = '0;
      hit_msg  = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (fired_ff[i] && age_ff[i] == idx) begin
            hit      = 1'b1;
            hit_rcv  = srcv_ff[i];
            hit_kind = skind_ff[i];
            hit_msg  = smsg_ff[i];
         end
      end
   end

   // times ten as two shifts
   assign best_wide = {{(SW - RW){1'b0}}, best_ff};
   assign shortest  = (best_wide << 3) + (best_wide << 1);

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         act_ff   <= req_action;
         msg_ff   <= req_message_id;
         kind_ff  <= req_event_kind;
         rcv_ff   <= req_receiver_id;
         delay_ff <= req_delay_ms;
         tick_ff  <= req_tick_count;
      end
      if (cmd.exec && act_ff == mset_pkg::ACT_REQUEST && free_found) begin
         rem_ff[free_idx]   <= new_rem;
         srcv_ff[free_idx]  <= rcv_ff;
         smsg_ff[free_idx]  <= msg_ff;
         skind_ff[free_idx] <= kind_ff;
      end
      if (cmd.exec && act_ff == mset_pkg::ACT_TICK) begin
         for (int i = 0; i < SLOTS; i++) begin
            if (active_ff[i] && rem_ff[i] > RW'(tick_ff)) begin
               rem_ff[i] <= rem_ff[i] - RW'(tick_ff);
            end
         end
      end
      if (cmd.exec) begin
         best_ff <= '0;
      end else if (cmd.min_step) begin
         if (active_ff[idx] && (best_ff == '0 || rem_ff[idx] < best_ff)) begin
            best_ff <= rem_ff[idx];
         end
      end
      if (cmd.match_step) begin
         if (active_ff[idx] && srcv_ff[idx] == rcv_ff && smsg_ff[idx] == msg_ff &&
             (!found_ff || age_ff[idx] < bage_ff)) begin
            bage_ff  <= age_ff[idx];
            bslot_ff <= idx;
         end
      end
      if (cmd.emit_step && hit) begin
         event_ff <= 1'b1;
         status_ff <= 1'b0;
         orcv_ff  <= hit_rcv;
         okind_ff <= hit_kind;
         omsg_ff  <= hit_msg;
         last_ff  <= (ecnt_ff + NW'(1) == nf_ff);
         short_ff <= shortest;
         oruntime_ff <= runtime_ff;
      end else if (cmd.finish && nf_ff == '0) begin
         event_ff <= 1'b0;
         status_ff <= err_ff;
         orcv_ff  <= '0;
         okind_ff <= '0;
         omsg_ff  <= '0;
         last_ff  <= 1'b1;
         short_ff <= shortest;
         oruntime_ff <= runtime_ff;
      end
   end

   // control state of the table
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= '0;
         fired_ff     <= '0;
         runtime_ff   <= '0;
         found_ff     <= 1'b0;
         err_ff       <= 1'b0;
         nf_ff        <= '0;
         ecnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            age_ff[i] <= '0;
            dec_ff[i] <= '0;
         end
      end else begin
         if ((cmd.emit_step && hit) || (cmd.finish && nf_ff == '0)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.exec) begin
            found_ff <= 1'b0;
            nf_ff    <= '0;
            ecnt_ff  <= '0;
            unique case (act_ff)
               mset_pkg::ACT_REQUEST: begin
                  err_ff <= !free_found;
                  if (free_found) begin
                     for (int i = 0; i < SLOTS; i++) begin
                        if (active_ff[i]) begin
                           age_ff[i] <= age_ff[i] + IW'(1);
                        end
                     end
                     active_ff[free_idx] <= 1'b1;
                     age_ff[free_idx]    <= '0;
                  end
               end
               mset_pkg::ACT_CANCEL: begin
                  err_ff <= 1'b0;
               end
               mset_pkg::ACT_TICK: begin
                  err_ff     <= 1'b0;
                  runtime_ff <= runtime_ff + {24'b0, tick_ff};
                  for (int i = 0; i < SLOTS; i++) begin
                     if (active_ff[i] && rem_ff[i] <= RW'(tick_ff)) begin
                        fired_ff[i]  <= 1'b1;
                        active_ff[i] <= 1'b0;
                     end
                  end
               end
               default: begin
                  err_ff <= 1'b1;
               end
            endcase
         end
         if (cmd.match_step) begin
            if (active_ff[idx] && srcv_ff[idx] == rcv_ff && smsg_ff[idx] == msg_ff &&
                (!found_ff || age_ff[idx] < bage_ff)) begin
               found_ff <= 1'b1;
            end
         end
         if (cmd.match_end) begin
            err_ff <= !found_ff;
            if (found_ff) begin
               // close the gap in the age order
               for (int i = 0; i < SLOTS; i++) begin
                  if (active_ff[i] && age_ff[i] > bage_ff) begin
                     age_ff[i] <= age_ff[i] - IW'(1);
                  end
               end
               active_ff[bslot_ff] <= 1'b0;
            end
         end
         if (cmd.min_step && fired_ff[idx]) begin
            nf_ff <= nf_ff + NW'(1);
            for (int i = 0; i < SLOTS; i++) begin
               if (age_ff[idx] < age_ff[i]) begin
                  dec_ff[i] <= dec_ff[i] + IW'(1);
               end
            end
         end
         if (cmd.emit_step && hit) begin
            ecnt_ff <= ecnt_ff + NW'(1);
         end
         if (cmd.finish) begin
            // ages of survivors drop by the number of newer (lower-age) fired entries
            for (int i = 0; i < SLOTS; i++) begin
               age_ff[i] <= age_ff[i] - dec_ff[i];
               dec_ff[i] <= '0;
            end
            fired_ff <= '0;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_event_valid    = event_ff;
   assign rsp_fired_receiver = orcv_ff;
   assign rsp_fired_kind     = okind_ff;
   assign rsp_fired_message  = omsg_ff;
   assign rsp_last           = last_ff;
   assign rsp_shortest_ms    = short_ff;
   assign rsp_runtime_ticks  = oruntime_ff;

endmodule
`default_nettype wire

@@ design/multi_slot_event_timer_table.sv @@
// top level of the multi-slot event timer table: controller plus datapath
// an item holds the controller for the transfer, an execute step, a minimum sweep over all SLOTS slots
// and a finish step; a cancel adds a match sweep over the slots and a match-end step, a firing tick
// an emit step for each of the SLOTS ages; emit and finish steps wait while the output register is full
// one item is worked at a time; the next is taken while the last result waits in the output register
// synchronous active-high reset empties the table and clears the runtime counter
`default_nettype none
module multi_slot_event_timer_table #(
   parameter int SLOTS = mset_pkg::SLOTS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [1:0]                    req_action,
   input  wire logic [7:0]                    req_message_id,
   input  wire logic [7:0]                    req_event_kind,
   input  wire logic signed [7:0]             req_receiver_id,
   input  wire logic [31:0]                   req_delay_ms,
   input  wire logic [7:0]                    req_tick_count,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_status,
   output logic                               rsp_event_valid,
   output logic signed [7:0]                  rsp_fired_receiver,
   output logic [7:0]                         rsp_fired_kind,
   output logic [7:0]                         rsp_fired_message,
   output logic                               rsp_last,
   output logic [mset_pkg::SHORT_W-1:0]       rsp_shortest_ms,
   output logic [31:0]                        rsp_runtime_ticks
);

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   mset_pkg::cmd_type    cmd;
   mset_pkg::status_type sts;
   logic [IW-1:0]        idx;

   mset_ctrl #(.SLOTS(SLOTS), .IW(IW)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd),
      .idx       (idx)
   );

   mset_dp #(.SLOTS(SLOTS), .IW(IW)) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .idx                (idx),
      .sts                (sts),
      .req_action         (req_action),
      .req_message_id     (req_message_id),
      .req_event_kind     (req_event_kind),
      .req_receiver_id    (req_receiver_id),
      .req_delay_ms       (req_delay_ms),
      .req_tick_count     (req_tick_count),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_event_valid    (rsp_event_valid),
      .rsp_fired_receiver (rsp_fired_receiver),
      .rsp_fired_kind     (rsp_fired_kind),
      .rsp_fired_message  (rsp_fired_message),
      .rsp_last           (rsp_last),
      .rsp_shortest_ms    (rsp_shortest_ms),
      .rsp_runtime_ticks  (rsp_runtime_ticks)
   );

endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
// testbench for the multi-slot event timer table: directed and random traffic, checked per result
`default_nettype none
module tb_top;

   localparam int NSLOT = 8;

   typedef struct packed {
      logic                            status;
      logic                            event_valid;
      logic signed [7:0]               fired_receiver;
      logic [7:0]                      fired_kind;
      logic [7:0]                      fired_message;
      logic                            last;
      logic [mset_pkg::SHORT_W-1:0]    shortest_ms;
      logic [31:0]                     runtime_ticks;
   } timer_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_action = '0;
   logic [7:0] req_message_id = '0;
   logic [7:0] req_event_kind = '0;
   logic signed [7:0] req_receiver_id = '0;
   logic [31:0] req_delay_ms = '0;
   logic [7:0] req_tick_count = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_status;
   logic rsp_event_valid;
   logic signed [7:0] rsp_fired_receiver;
   logic [7:0] rsp_fired_kind;
   logic [7:0] rsp_fired_message;
   logic rsp_last;
   logic [mset_pkg::SHORT_W-1:0] rsp_shortest_ms;
   logic [31:0] rsp_runtime_ticks;

   multi_slot_event_timer_table #(.SLOTS(NSLOT)) u_dut (.*);

   // predictor copy of the table
   logic              tbl_active [NSLOT];
   logic [31:0]       tbl_remaining [NSLOT];
   logic [7:0]        tbl_receiver [NSLOT];
   logic [7:0]        tbl_message [NSLOT];
   logic [7:0]        tbl_kind [NSLOT];
   int                tbl_age [NSLOT];
   logic [31:0]       tbl_runtime;

   timer_result_type pending_results[$];
   int  error_count = 0;
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("[multi_slot_event_timer_table] ERROR");
      $finish;
   end

   function automatic logic [mset_pkg::SHORT_W-1:0] table_shortest();
      logic [31:0] best;
      best = 0;
      for (int i = 0; i < NSLOT; i++)
         if (tbl_active[i] && (best == 0 || tbl_remaining[i] < best)) best = tbl_remaining[i];
      return mset_pkg::SHORT_W'(best) * mset_pkg::SHORT_W'(mset_pkg::TICK_MS);
   endfunction

   function automatic int table_slot_of_age(int a);
      for (int i = 0; i < NSLOT; i++)
         if (tbl_active[i] && tbl_age[i] == a) return i;
      return -1;
   endfunction

   function automatic void table_renumber();
      int fresh [NSLOT];
      for (int i = 0; i < NSLOT; i++) begin
         fresh[i] = 0;
         if (tbl_active[i])
            for (int j = 0; j < NSLOT; j++)
               if (tbl_active[j] && tbl_age[j] < tbl_age[i]) fresh[i]++;
      end
      for (int i = 0; i < NSLOT; i++) tbl_age[i] = fresh[i];
   endfunction

   function automatic void push_plain(logic st);
      timer_result_type r;
      r = '0;
      r.status = st;
      r.last = 1'b1;
      r.shortest_ms = table_shortest();
      r.runtime_ticks = tbl_runtime;
      pending_results.push_back(r);
   endfunction

   // work out the results of one accepted item and advance the table
   function automatic void predict_timer_action(logic [1:0] act, logic [7:0] msg,
         logic [7:0] kind, logic [7:0] rcv, logic [31:0] delay, logic [7:0] ticks);
      int fired [NSLOT];
      int nf, s, slot;
      timer_result_type r;
      nf = 0;
      slot = -1;
      case (mset_pkg::action_type'(act))
         mset_pkg::ACT_REQUEST: begin
            for (int i = NSLOT - 1; i >= 0; i--) if (!tbl_active[i]) slot = i;
            if (slot < 0) begin
               push_plain(1'b1);
            end else begin
               for (int i = 0; i < NSLOT; i++) if (tbl_active[i]) tbl_age[i]++;
               tbl_active[slot] = 1'b1;
               tbl_age[slot] = 0;
               tbl_remaining[slot] = (delay > 32'(mset_pkg::MIN_TICKS * mset_pkg::TICK_MS)) ?
                  delay / 32'(mset_pkg::TICK_MS) + 32'd1 : 32'(mset_pkg::MIN_TICKS);
               tbl_receiver[slot] = rcv;
               tbl_message[slot] = msg;
               tbl_kind[slot] = kind;
               push_plain(1'b0);
            end
         end
         mset_pkg::ACT_CANCEL: begin
            for (int a = 0; a < NSLOT && slot < 0; a++) begin
               s = table_slot_of_age(a);
               if (s < 0) break;
               if (tbl_receiver[s] == rcv && tbl_message[s] == msg) slot = s;
            end
            if (slot >= 0) begin
               tbl_active[slot] = 1'b0;
               table_renumber();
            end
            push_plain(slot < 0);
         end
         mset_pkg::ACT_TICK: begin
            tbl_runtime += ticks;
            for (int a = 0; a < NSLOT; a++) begin
               s = table_slot_of_age(a);
               if (s < 0) break;
               if (tbl_remaining[s] <= ticks) fired[nf++] = s;
               else tbl_remaining[s] -= ticks;
            end
            for (int n = 0; n < nf; n++) tbl_active[fired[n]] = 1'b0;
            table_renumber();
            if (nf == 0) push_plain(1'b0);
            for (int n = 0; n < nf; n++) begin
               r = '0;
               r.event_valid = 1'b1;
               r.fired_receiver = tbl_receiver[fired[n]];
               r.fired_kind = tbl_kind[fired[n]];
               r.fired_message = tbl_message[fired[n]];
               r.last = (n == nf - 1);
               r.shortest_ms = table_shortest();
               r.runtime_ticks = tbl_runtime;
               pending_results.push_back(r);
            end
         end
         default: push_plain(1'b1);
      endcase
   endfunction

   // valid stays up across back-to-back items and drops only while the sender idles
   task automatic send_timer_item(logic [1:0] act, logic [7:0] msg, logic [7:0] kind,
         logic [7:0] rcv, logic [31:0] delay, logic [7:0] ticks);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_message_id <= msg;
      req_event_kind <= kind;
      req_receiver_id <= rcv;
      req_delay_ms <= delay;
      req_tick_count <= ticks;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_timer_action(act, msg, kind, rcv, delay, ticks);
      @(negedge clock);
   endtask

   // receiver stall pattern
   always @(negedge clock)
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);

   always @(posedge clock) begin
      timer_result_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("result transfer with nothing expected");
            error_count++;
         end else begin
            exp_r = pending_results.pop_front();
            if (rsp_status !== exp_r.status) begin
               $error("status exp %0h got %0h", exp_r.status, rsp_status); error_count++;
            end
            if (rsp_event_valid !== exp_r.event_valid) begin
               $error("event_valid exp %0h got %0h", exp_r.event_valid, rsp_event_valid);
               error_count++;
            end
            if (rsp_fired_receiver !== exp_r.fired_receiver) begin
               $error("fired_receiver exp %0d got %0d", exp_r.fired_receiver,
                  rsp_fired_receiver);
               error_count++;
            end
            if (rsp_fired_kind !== exp_r.fired_kind) begin
               $error("fired_kind exp %0h got %0h", exp_r.fired_kind, rsp_fired_kind);
               error_count++;
            end
            if (rsp_fired_message !== exp_r.fired_message) begin
               $error("fired_message exp %0h got %0h", exp_r.fired_message,
                  rsp_fired_message);
               error_count++;
            end
            if (rsp_last !== exp_r.last) begin
               $error("last exp %0h got %0h", exp_r.last, rsp_last); error_count++;
            end
            if (rsp_shortest_ms !== exp_r.shortest_ms) begin
               $error("shortest_ms exp %0d got %0d", exp_r.shortest_ms, rsp_shortest_ms);
               error_count++;
            end
            if (rsp_runtime_ticks !== exp_r.runtime_ticks) begin
               $error("runtime_ticks exp %0d got %0d", exp_r.runtime_ticks,
                  rsp_runtime_ticks);
               error_count++;
            end
         end
      end
   end

   task automatic send_request(logic [7:0] msg, logic [7:0] rcv, logic [31:0] delay);
      send_timer_item(mset_pkg::ACT_REQUEST, msg, 8'($urandom), rcv, delay, 8'($urandom));
   endtask

   task automatic send_tick(logic [7:0] ticks);
      send_timer_item(mset_pkg::ACT_TICK, 8'($urandom), 8'($urandom), 8'($urandom),
         $urandom, ticks);
   endtask

   // field extremes, rounding of the delay, full table, cancel hit and miss, bad action
   task automatic test_directed();
      send_request(8'h00, 8'h80, 32'd0);
      send_request(8'hFF, 8'h7F, 32'd20);
      send_request(8'h12, 8'h01, 32'd21);
      send_request(8'h34, 8'hFF, 32'hFFFF_FFFF);
      send_request(8'h12, 8'h01, 32'd35);
      send_request(8'h56, 8'h02, 32'd100);
      send_request(8'h57, 8'h03, 32'd9);
      send_request(8'h58, 8'h04, 32'd55);
      send_request(8'h59, 8'h05, 32'd60);
      send_timer_item(mset_pkg::ACT_CANCEL, 8'h12, 8'h0, 8'h01, 32'h0, 8'h0);
      send_timer_item(mset_pkg::ACT_CANCEL, 8'h99, 8'h0, 8'h01, 32'h0, 8'h0);
      send_timer_item(mset_pkg::ACT_BAD, 8'hAA, 8'h55, 8'h11, 32'h5555_AAAA, 8'hFF);
      send_tick(8'd0);
      send_tick(8'd1);
      send_tick(8'd2);
      send_tick(8'd5);
      send_tick(8'd255);
      send_request(8'h60, 8'h06, 32'd30);
      send_tick(8'd255);
      send_tick(8'd255);
   endtask

   // mostly requests and ticks with small delays so timers fire; some cancels from the requests' key range
   task automatic test_random(int count);
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 40)
            send_request(8'($urandom_range(7)), 8'($urandom_range(3)),
               ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(150)));
         else if (pick < 55)
            send_timer_item(mset_pkg::ACT_CANCEL, 8'($urandom_range(7)), 8'($urandom),
               8'($urandom_range(3)), $urandom, 8'($urandom));
         else if (pick < 95)
            send_tick(($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(4)));
         else
            send_timer_item(mset_pkg::ACT_BAD, 8'($urandom), 8'($urandom), 8'($urandom),
               $urandom, 8'($urandom));
      end
   endtask

   initial begin
      for (int i = 0; i < NSLOT; i++) begin
         tbl_active[i] = 1'b0; tbl_age[i] = 0; tbl_remaining[i] = 0;
         tbl_receiver[i] = 0; tbl_message[i] = 0; tbl_kind[i] = 0;
      end
      tbl_runtime = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_idle_pct = 22; recv_idle_pct = 74;
      test_directed();
      test_random(70);
      send_idle_pct = 74; recv_idle_pct = 22;
      test_random(70);
      send_idle_pct = 0; recv_idle_pct = 0;
      test_random(70);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0)
         $display("[multi_slot_event_timer_table] OK");
      else
         $display("[multi_slot_event_timer_table] ERROR");
      $finish;
   end
endmodule
`default_nettype wire
